### rtl/cau_pkg.sv
package cau_pkg;

    // Port and default sizes.
    localparam int PORT_W          = 32;
    localparam int DEF_DATA_WIDTH  = 32;
    localparam int DEF_FRAC_BITS   = 16;

    // Command queue between front and back end.
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    // CORDIC vectoring constants.
    localparam int CORDIC_ITER     = 32;
    localparam int CORDIC_PRESHIFT = 30;
    localparam int ANGLE_W         = 32;

    // Operation codes.
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;
    localparam logic [2:0] OP_MAG   = 3'd5;
    localparam logic [2:0] OP_PHASE = 3'd6;

    // Status codes.
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_SAT = 2'd1;
    localparam logic [1:0] STAT_DZ  = 2'd2;

    // Class of work decided by the front end.
    typedef enum logic [1:0] {
        CL_SIMPLE,
        CL_PROD,
        CL_PHASE,
        CL_FAULT
    } class_t;

    // One queued transaction.
    typedef struct packed {
        logic [2:0]               op;
        class_t                   cls;
        logic [2:0]               last_step;
        logic signed [PORT_W-1:0] a_re;
        logic signed [PORT_W-1:0] a_im;
        logic signed [PORT_W-1:0] b_re;
        logic signed [PORT_W-1:0] b_im;
    } item_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_PREP,
        BK_CHK,
        BK_DIV,
        BK_SQRT,
        BK_CORDIC,
        BK_FIN
    } back_state_t;

    // atan(2^-i) in unsigned Q0.32, rounded.
    function automatic logic [ANGLE_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd3373259426;
            5'd1:    v = 32'd1991351318;
            5'd2:    v = 32'd1052175346;
            5'd3:    v = 32'd534100635;
            5'd4:    v = 32'd268086748;
            5'd5:    v = 32'd134174063;
            5'd6:    v = 32'd67103403;
            5'd7:    v = 32'd33553749;
            5'd8:    v = 32'd16777131;
            5'd9:    v = 32'd8388597;
            5'd10:   v = 32'd4194303;
            5'd11:   v = 32'd2097152;
            5'd12:   v = 32'd1048576;
            5'd13:   v = 32'd524288;
            5'd14:   v = 32'd262144;
            5'd15:   v = 32'd131072;
            5'd16:   v = 32'd65536;
            5'd17:   v = 32'd32768;
            5'd18:   v = 32'd16384;
            5'd19:   v = 32'd8192;
            5'd20:   v = 32'd4096;
            5'd21:   v = 32'd2048;
            5'd22:   v = 32'd1024;
            5'd23:   v = 32'd512;
            5'd24:   v = 32'd256;
            5'd25:   v = 32'd128;
            5'd26:   v = 32'd64;
            5'd27:   v = 32'd32;
            5'd28:   v = 32'd16;
            5'd29:   v = 32'd8;
            5'd30:   v = 32'd4;
            default: v = 32'd2;
        endcase
        return v;
    endfunction

endpackage

### rtl/cau_front.sv
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH
) (
    input  logic                              start,
    input  logic                              full,
    input  logic [2:0]                        operation,
    input  logic signed [cau_pkg::PORT_W-1:0] a_re,
    input  logic signed [cau_pkg::PORT_W-1:0] a_im,
    input  logic signed [cau_pkg::PORT_W-1:0] b_re,
    input  logic signed [cau_pkg::PORT_W-1:0] b_im,
    output logic                              busy,
    output logic                              push,
    output cau_pkg::item_t                    item
);

    localparam int WID = (DATA_WIDTH > cau_pkg::PORT_W) ? cau_pkg::PORT_W : DATA_WIDTH;

    // Keep the low WID bits and sign extend them back to port width.
    function automatic logic signed [cau_pkg::PORT_W-1:0] sext(
        input logic [cau_pkg::PORT_W-1:0] raw
    );
        logic signed [WID-1:0] low;
        low = raw[WID-1:0];
        return cau_pkg::PORT_W'(low);
    endfunction

    // A transaction is taken whenever start is high and the queue has room.
    assign busy = full;
    assign push = start && !full;

    // Normalize operands and decide which back end path the item takes.
    always_comb
    begin
        item.op        = operation;
        item.a_re      = sext(a_re);
        item.a_im      = sext(a_im);
        item.b_re      = sext(b_re);
        item.b_im      = sext(b_im);
        item.cls       = cau_pkg::CL_SIMPLE;
        item.last_step = 3'd0;
        case (operation)
            cau_pkg::OP_MUL, cau_pkg::OP_SCALE:
            begin
                item.cls       = cau_pkg::CL_PROD;
                item.last_step = 3'd3;
            end
            cau_pkg::OP_DIV:
            begin
                item.cls       = cau_pkg::CL_PROD;
                item.last_step = 3'd5;
            end
            cau_pkg::OP_MAG:
            begin
                item.cls       = cau_pkg::CL_PROD;
                item.last_step = 3'd1;
            end
            cau_pkg::OP_PHASE:
            begin
                item.cls = (item.a_re == '0) ? cau_pkg::CL_FAULT : cau_pkg::CL_PHASE;
            end
            default:
            begin
                item.cls = cau_pkg::CL_SIMPLE;
            end
        endcase
    end

endmodule

### rtl/cau_queue.sv
module cau_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cau_pkg::item_t item_in,
    input  logic           pop,
    output logic           valid,
    output logic           full,
    output cau_pkg::item_t item_out
);

    cau_pkg::item_t                slot_reg [cau_pkg::QUEUE_DEPTH];
    logic [cau_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [cau_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [cau_pkg::QPTR_W:0]      count_reg;

    assign valid    = (count_reg != '0);
    assign full     = (count_reg == (cau_pkg::QPTR_W + 1)'(cau_pkg::QUEUE_DEPTH));
    assign item_out = slot_reg[rd_ptr_reg];

    // Pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### rtl/cau_back.sv
module cau_back #(
    parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid,
    input  cau_pkg::item_t                    item,
    output logic                              pop,
    output logic                              done,
    output logic signed [cau_pkg::PORT_W-1:0] res_re,
    output logic signed [cau_pkg::PORT_W-1:0] res_im,
    output logic [1:0]                        status
);

    localparam int WID     = (DATA_WIDTH > cau_pkg::PORT_W) ? cau_pkg::PORT_W : DATA_WIDTH;
    localparam int PW      = 2 * WID;
    localparam int F       = FRAC_BITS;
    localparam longint MAXV    = (longint'(1) << (WID - 1)) - 1;
    localparam longint DIV_LIM = (MAXV >> F) + 2;
    localparam int NQ      = $clog2(DIV_LIM << (F + 1));
    localparam int LIM_W   = $clog2(DIV_LIM + 1);
    localparam int RW      = PW + F + NQ + 1;
    localparam int SQ_ITER = PW / 2;
    localparam int CW      = WID + cau_pkg::CORDIC_PRESHIFT + 2;
    localparam int ZW      = cau_pkg::ANGLE_W + 4;
    localparam int SW      = PW + 8;
    localparam int MAXIT   = (NQ > SQ_ITER)
                           ? ((NQ > cau_pkg::CORDIC_ITER) ? NQ : cau_pkg::CORDIC_ITER)
                           : ((SQ_ITER > cau_pkg::CORDIC_ITER) ? SQ_ITER : cau_pkg::CORDIC_ITER);
    localparam int CNTW    = $clog2(MAXIT + 1);
    localparam int CIDX_W  = $clog2(cau_pkg::CORDIC_ITER);

    localparam logic signed [WID-1:0] SAT_MAX = {1'b0, {(WID - 1){1'b1}}};
    localparam logic signed [WID-1:0] SAT_MIN = {1'b1, {(WID - 1){1'b0}}};

    // Saturate to the data width; the top bit of the result is the flag.
    function automatic logic [WID:0] sat_fn(input logic signed [SW-1:0] v);
        logic [WID:0] r;
        if (v > SW'(SAT_MAX))
        begin
            r = {1'b1, SAT_MAX};
        end
        else if (v < SW'(SAT_MIN))
        begin
            r = {1'b1, SAT_MIN};
        end
        else
        begin
            r = {1'b0, v[WID-1:0]};
        end
        return r;
    endfunction

    cau_pkg::back_state_t state_reg, state_next;

    logic [2:0]              op_reg;
    logic [2:0]              last_step_reg;
    logic [2:0]              step_reg;
    logic signed [WID-1:0]   ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [PW-1:0]    prod_reg [6];
    logic                    dz_reg;
    logic [CNTW-1:0]         cnt_reg;

    logic [PW-1:0]           num_re_reg, num_im_reg, den_reg;
    logic                    neg_re_reg, neg_im_reg;
    logic                    ovf_re_reg, ovf_im_reg;
    logic [RW-1:0]           rem_re_reg, rem_im_reg, dsh_reg;
    logic [NQ-1:0]           q_re_reg, q_im_reg;

    logic [PW:0]             sq_n_reg, sq_res_reg, sq_bit_reg;

    logic signed [CW-1:0]    cx_reg, cy_reg;
    logic signed [ZW-1:0]    cz_reg;

    logic                    done_reg;
    logic signed [WID-1:0]   out_re_reg, out_im_reg;
    logic [1:0]              status_reg;

    // Shared multiplier, registered into the product bank.
    logic signed [WID-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]    mul_p;

    always_comb
    begin
        mul_a = ar_reg;
        mul_b = br_reg;
        if (op_reg == cau_pkg::OP_MAG)
        begin
            mul_a = (step_reg == 3'd0) ? ar_reg : ai_reg;
            mul_b = mul_a;
        end
        else
        begin
            case (step_reg)
                3'd0:    begin mul_a = ar_reg; mul_b = br_reg; end
                3'd1:    begin mul_a = ai_reg; mul_b = bi_reg; end
                3'd2:    begin mul_a = ar_reg; mul_b = bi_reg; end
                3'd3:    begin mul_a = ai_reg; mul_b = br_reg; end
                3'd4:    begin mul_a = br_reg; mul_b = br_reg; end
                3'd5:    begin mul_a = bi_reg; mul_b = bi_reg; end
                default: begin mul_a = '0;     mul_b = '0;     end
            endcase
        end
        mul_p = mul_a * mul_b;
    end

    // Quotient setup: denominator and signed numerators from the products, plus the sum of squares for the magnitude.
    logic [PW-1:0]           den_w;
    logic signed [PW:0]      sre_w, sim_w;
    logic [PW-1:0]           s2_w;

    always_comb
    begin
        den_w = prod_reg[4] + prod_reg[5];
        sre_w = (PW + 1)'(prod_reg[0]) + (PW + 1)'(prod_reg[1]);
        sim_w = (PW + 1)'(prod_reg[3]) - (PW + 1)'(prod_reg[2]);
        s2_w  = prod_reg[0] + prod_reg[1];
    end

    // Integer part range check for the quotient.
    logic [PW+LIM_W-1:0]     bound_w;
    assign bound_w = (PW + LIM_W)'(den_reg) * (PW + LIM_W)'(DIV_LIM);

    // One restoring division step for both parts.
    logic                    ge_re, ge_im;
    assign ge_re = (rem_re_reg >= dsh_reg);
    assign ge_im = (rem_im_reg >= dsh_reg);

    // One square root step.
    logic [PW:0]             sq_t;
    logic                    sq_ge;
    assign sq_t  = sq_res_reg + sq_bit_reg;
    assign sq_ge = (sq_n_reg >= sq_t);

    // One CORDIC vectoring step.
    logic signed [CW-1:0]    cdx, cdy;
    logic signed [ZW-1:0]    cang;
    assign cdx  = cy_reg >>> cnt_reg;
    assign cdy  = cx_reg >>> cnt_reg;
    assign cang = ZW'(cau_pkg::atan_entry(cnt_reg[CIDX_W-1:0]));

    // Final rounding, sign and saturation for every operation.
    logic signed [WID-1:0]   fin_re, fin_im;
    logic [1:0]              fin_stat;

    always_comb
    begin
        logic [WID:0]          sr, si;
        logic signed [PW+1:0]  pre, pim;
        logic [NQ:0]           tre, tim;
        logic signed [NQ+1:0]  vre, vim;
        logic [PW:0]           sq_s;
        logic signed [ZW-1:0]  zq;
        logic                  flag;

        sr   = '0;
        si   = '0;
        pre  = '0;
        pim  = '0;
        tre  = '0;
        tim  = '0;
        vre  = '0;
        vim  = '0;
        sq_s = '0;
        zq   = '0;
        flag = 1'b0;
        case (op_reg)
            cau_pkg::OP_ADD:
            begin
                sr = sat_fn(SW'((WID + 1)'(ar_reg) + (WID + 1)'(br_reg)));
                si = sat_fn(SW'((WID + 1)'(ai_reg) + (WID + 1)'(bi_reg)));
            end
            cau_pkg::OP_SUB:
            begin
                sr = sat_fn(SW'((WID + 1)'(ar_reg) - (WID + 1)'(br_reg)));
                si = sat_fn(SW'((WID + 1)'(ai_reg) - (WID + 1)'(bi_reg)));
            end
            cau_pkg::OP_MUL, cau_pkg::OP_SCALE:
            begin
                if (op_reg == cau_pkg::OP_MUL)
                begin
                    pre = (PW + 2)'(prod_reg[0]) - (PW + 2)'(prod_reg[1]);
                    pim = (PW + 2)'(prod_reg[2]) + (PW + 2)'(prod_reg[3]);
                end
                else
                begin
                    pre = (PW + 2)'(prod_reg[0]);
                    pim = (PW + 2)'(prod_reg[3]);
                end
                pre = (pre + (PW + 2)'(longint'(1) << (F - 1))) >>> F;
                pim = (pim + (PW + 2)'(longint'(1) << (F - 1))) >>> F;
                sr  = sat_fn(SW'(pre));
                si  = sat_fn(SW'(pim));
            end
            cau_pkg::OP_DIV:
            begin
                tre = {1'b0, q_re_reg} + 1'b1;
                tim = {1'b0, q_im_reg} + 1'b1;
                vre = {2'b00, tre[NQ:1]};
                vim = {2'b00, tim[NQ:1]};
                if (neg_re_reg)
                begin
                    vre = -vre;
                end
                if (neg_im_reg)
                begin
                    vim = -vim;
                end
                sr = ovf_re_reg ? {1'b1, (neg_re_reg ? SAT_MIN : SAT_MAX)} : sat_fn(SW'(vre));
                si = ovf_im_reg ? {1'b1, (neg_im_reg ? SAT_MIN : SAT_MAX)} : sat_fn(SW'(vim));
            end
            cau_pkg::OP_MAG:
            begin
                sq_s = sq_res_reg + ((sq_n_reg > sq_res_reg) ? 1'b1 : 1'b0);
                sr   = sat_fn(SW'(signed'({1'b0, sq_s})));
            end
            cau_pkg::OP_PHASE:
            begin
                zq = (cz_reg + ZW'(longint'(1) << (31 - F))) >>> (32 - F);
                if ((ai_reg != '0) && ((ar_reg < 0) != (ai_reg < 0)))
                begin
                    zq = -zq;
                end
                sr = sat_fn(SW'(zq));
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        flag     = sr[WID] | si[WID];
        fin_re   = dz_reg ? '0 : sr[WID-1:0];
        fin_im   = dz_reg ? '0 : si[WID-1:0];
        fin_stat = dz_reg ? cau_pkg::STAT_DZ : (flag ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK);
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cau_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and queue pop.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            cau_pkg::BK_IDLE:
            begin
                if (valid)
                begin
                    pop = 1'b1;
                    case (item.cls)
                        cau_pkg::CL_PROD:  state_next = cau_pkg::BK_MUL;
                        cau_pkg::CL_PHASE: state_next = cau_pkg::BK_CORDIC;
                        default:           state_next = cau_pkg::BK_FIN;
                    endcase
                end
            end
            cau_pkg::BK_MUL:
            begin
                if (step_reg == last_step_reg)
                begin
                    state_next = cau_pkg::BK_PREP;
                end
            end
            cau_pkg::BK_PREP:
            begin
                case (op_reg)
                    cau_pkg::OP_DIV:
                        state_next = (den_w == '0) ? cau_pkg::BK_FIN : cau_pkg::BK_CHK;
                    cau_pkg::OP_MAG:
                        state_next = cau_pkg::BK_SQRT;
                    default:
                        state_next = cau_pkg::BK_FIN;
                endcase
            end
            cau_pkg::BK_CHK:
            begin
                state_next = cau_pkg::BK_DIV;
            end
            cau_pkg::BK_DIV:
            begin
                if (cnt_reg == CNTW'(NQ - 1))
                begin
                    state_next = cau_pkg::BK_FIN;
                end
            end
            cau_pkg::BK_SQRT:
            begin
                if (cnt_reg == CNTW'(SQ_ITER - 1))
                begin
                    state_next = cau_pkg::BK_FIN;
                end
            end
            cau_pkg::BK_CORDIC:
            begin
                if (cnt_reg == CNTW'(cau_pkg::CORDIC_ITER - 1))
                begin
                    state_next = cau_pkg::BK_FIN;
                end
            end
            cau_pkg::BK_FIN:
            begin
                state_next = cau_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = cau_pkg::BK_IDLE;
            end
        endcase
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == cau_pkg::BK_FIN);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cau_pkg::BK_IDLE:
            begin
                op_reg        <= item.op;
                last_step_reg <= item.last_step;
                ar_reg        <= item.a_re[WID-1:0];
                ai_reg        <= item.a_im[WID-1:0];
                br_reg        <= item.b_re[WID-1:0];
                bi_reg        <= item.b_im[WID-1:0];
                dz_reg        <= (item.cls == cau_pkg::CL_FAULT);
                step_reg      <= '0;
                cnt_reg       <= '0;
                cx_reg <= CW'({1'b0, (item.a_re[WID-1] ? -item.a_re[WID-1:0]
                                                       : item.a_re[WID-1:0])})
                          <<< cau_pkg::CORDIC_PRESHIFT;
                cy_reg <= CW'({1'b0, (item.a_im[WID-1] ? -item.a_im[WID-1:0]
                                                       : item.a_im[WID-1:0])})
                          <<< cau_pkg::CORDIC_PRESHIFT;
                cz_reg <= '0;
            end
            cau_pkg::BK_MUL:
            begin
                prod_reg[step_reg] <= mul_p;
                step_reg           <= step_reg + 1'b1;
            end
            cau_pkg::BK_PREP:
            begin
                den_reg    <= den_w;
                dz_reg     <= (op_reg == cau_pkg::OP_DIV) && (den_w == '0);
                neg_re_reg <= sre_w[PW];
                neg_im_reg <= sim_w[PW];
                num_re_reg <= sre_w[PW] ? PW'(-sre_w) : PW'(sre_w);
                num_im_reg <= sim_w[PW] ? PW'(-sim_w) : PW'(sim_w);
                sq_n_reg   <= (PW + 1)'(s2_w);
                sq_res_reg <= '0;
                sq_bit_reg <= (PW + 1)'(1) << (PW - 2);
                cnt_reg    <= '0;
            end
            cau_pkg::BK_CHK:
            begin
                ovf_re_reg <= ((PW + LIM_W)'(num_re_reg) >= bound_w);
                ovf_im_reg <= ((PW + LIM_W)'(num_im_reg) >= bound_w);
                rem_re_reg <= RW'(num_re_reg) << (F + 1);
                rem_im_reg <= RW'(num_im_reg) << (F + 1);
                dsh_reg    <= RW'(den_reg) << (NQ - 1);
                q_re_reg   <= '0;
                q_im_reg   <= '0;
                cnt_reg    <= '0;
            end
            cau_pkg::BK_DIV:
            begin
                rem_re_reg <= ge_re ? (rem_re_reg - dsh_reg) : rem_re_reg;
                rem_im_reg <= ge_im ? (rem_im_reg - dsh_reg) : rem_im_reg;
                q_re_reg   <= {q_re_reg[NQ-2:0], ge_re};
                q_im_reg   <= {q_im_reg[NQ-2:0], ge_im};
                dsh_reg    <= dsh_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            cau_pkg::BK_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_n_reg   <= sq_n_reg - sq_t;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            cau_pkg::BK_CORDIC:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + cdx;
                    cy_reg <= cy_reg - cdy;
                    cz_reg <= cz_reg + cang;
                end
                else if (cy_reg < 0)
                begin
                    cx_reg <= cx_reg - cdx;
                    cy_reg <= cy_reg + cdy;
                    cz_reg <= cz_reg - cang;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            cau_pkg::BK_FIN:
            begin
                out_re_reg <= fin_re;
                out_im_reg <= fin_im;
                status_reg <= fin_stat;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done   = done_reg;
    assign res_re = cau_pkg::PORT_W'(out_re_reg);
    assign res_im = cau_pkg::PORT_W'(out_im_reg);
    assign status = status_reg;

endmodule

### rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed fixed-point operands. A transaction is taken on a clock
// edge with start high and busy low; busy rises only when the four-entry command queue is
// full. Each result appears for exactly one cycle with done high and cannot be stalled, so
// the receiver must take it then. The back end runs one transaction at a time: add and
// subtract go straight to rounding, multiply and scale make four passes through the one
// shared multiplier, magnitude forms two products and then runs a one-bit-per-cycle square
// root, phase runs a 32-step CORDIC, and divide forms six products and then runs a
// restoring divider that retires one quotient bit per cycle (NQ = 33 quotient bits at the
// default widths). Results come out in the order the transactions were taken.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        operation,
    input  logic signed [cau_pkg::PORT_W-1:0] a_re,
    input  logic signed [cau_pkg::PORT_W-1:0] a_im,
    input  logic signed [cau_pkg::PORT_W-1:0] b_re,
    input  logic signed [cau_pkg::PORT_W-1:0] b_im,
    output logic                              done,
    output logic signed [cau_pkg::PORT_W-1:0] res_re,
    output logic signed [cau_pkg::PORT_W-1:0] res_im,
    output logic [1:0]                        status
);

    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;
    cau_pkg::item_t front_item;
    cau_pkg::item_t head_item;

    // Operand normalization and classification.
    cau_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .start     (start),
        .full      (q_full),
        .operation (operation),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .busy      (busy),
        .push      (push),
        .item      (front_item)
    );

    // Command queue between the two halves.
    cau_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .valid    (q_valid),
        .full     (q_full),
        .item_out (head_item)
    );

    // Arithmetic sequencer.
    cau_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (q_valid),
        .item   (head_item),
        .pop    (pop),
        .done   (done),
        .res_re (res_re),
        .res_im (res_im),
        .status (status)
    );

endmodule
